// ----- hw/rtl/gmb_pkg.sv -----
// Shared types, constants and helpers of the grid maze BFS solver.
`timescale 1ns / 1ps
package gmb_pkg;

	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W    = 6;
	localparam int COL_W    = 6;
	localparam int CELL_W   = ROW_W + COL_W;
	localparam int PTR_W    = CELL_W + 1;
	localparam int DIM_W    = 7;

	localparam logic [DIM_W-1:0] DIM_MAX_ROWS = DIM_W'(MAX_ROWS);
	localparam logic [DIM_W-1:0] DIM_MAX_COLS = DIM_W'(MAX_COLS);

	// Stored cell codes
	localparam logic [2:0] CODE_OPEN   = 3'd0;
	localparam logic [2:0] CODE_WALL   = 3'd1;
	localparam logic [2:0] CODE_START  = 3'd2;
	localparam logic [2:0] CODE_FINISH = 3'd3;
	localparam logic [2:0] CODE_PATH   = 3'd4;

	// Configuration register indexes
	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_SOLVE = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_ACK     = 2'd0,
		ST_FOUND   = 2'd1,
		ST_NOPATH  = 2'd2,
		ST_INVALID = 2'd3
	} status_t;

	// Direction of the move into a cell
	typedef enum logic [1:0] {
		DIR_N = 2'd0,
		DIR_W = 2'd1,
		DIR_S = 2'd2,
		DIR_E = 2'd3
	} dir_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_WAIT,
		S_SWEEP,
		S_SW_TAIL,
		S_CHECK,
		S_POP,
		S_POP_WAIT,
		S_CUR,
		S_NB_READ,
		S_NB_CHECK,
		S_TR_READ,
		S_TR_WAIT
	} state_t;

	typedef struct packed {
		logic    item_wr;
		logic    item_rd;
		logic    sweep_init;
		logic    sweep_run;
		logic    seed;
		logic    pop;
		logic    load_cur;
		logic    nb_read;
		logic    nb_check;
		logic    dir_next;
		logic    tr_init;
		logic    tr_read;
		logic    tr_step;
		logic    res_load;
		logic    res_use_rd;
		status_t res_status;
	} cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic maze_ok;
		logic queue_empty;
		logic cur_is_finish;
		logic nb_ok;
		logic dir_last;
		logic tr_at_start;
	} stat_t;

	// Clamp a dimension register into 1..max
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] mx);
		logic [DIM_W-1:0] r;
		if (v == '0) r = DIM_W'(1);
		else if (v > mx) r = mx;
		else r = v;
		return r;
	endfunction

endpackage

// ----- hw/rtl/gmb_ctrl.sv -----
// Controller state machine of the grid maze BFS solver.
`timescale 1ns / 1ps
module gmb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	input  gmb_pkg::op_t   opcode,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  gmb_pkg::stat_t stat,
	output gmb_pkg::cmd_t  cmd
);
	import gmb_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	// State register and result-valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	// Next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		s_tready = (state_q == S_IDLE) && !out_valid_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid && s_tready) begin
					case (opcode)
						OP_WRITE: begin
							cmd.item_wr    = 1'b1;
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_ACK;
						end
						OP_READ: begin
							cmd.item_rd = 1'b1;
							state_d     = S_RD_WAIT;
						end
						OP_SOLVE: begin
							cmd.sweep_init = 1'b1;
							state_d        = S_SWEEP;
						end
						default: begin
							cmd.res_load   = 1'b1;
							cmd.res_status = ST_ACK;
						end
					endcase
				end
			end
			S_RD_WAIT: begin
				cmd.res_load   = 1'b1;
				cmd.res_use_rd = 1'b1;
				cmd.res_status = ST_ACK;
				state_d        = S_IDLE;
			end
			S_SWEEP: begin
				cmd.sweep_run = 1'b1;
				if (stat.sweep_last) state_d = S_SW_TAIL;
			end
			S_SW_TAIL: state_d = S_CHECK;
			S_CHECK: begin
				if (!stat.maze_ok) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_INVALID;
					state_d        = S_IDLE;
				end else begin
					cmd.seed = 1'b1;
					state_d  = S_POP;
				end
			end
			S_POP: begin
				if (stat.queue_empty) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_NOPATH;
					state_d        = S_IDLE;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_POP_WAIT;
				end
			end
			S_POP_WAIT: begin
				cmd.load_cur = 1'b1;
				state_d      = S_CUR;
			end
			S_CUR: begin
				if (stat.cur_is_finish) begin
					cmd.tr_init = 1'b1;
					state_d     = S_TR_READ;
				end else begin
					state_d = S_NB_READ;
				end
			end
			S_NB_READ: begin
				if (stat.nb_ok) begin
					cmd.nb_read = 1'b1;
					state_d     = S_NB_CHECK;
				end else if (stat.dir_last) begin
					state_d = S_POP;
				end else begin
					cmd.dir_next = 1'b1;
				end
			end
			S_NB_CHECK: begin
				cmd.nb_check = 1'b1;
				state_d      = stat.dir_last ? S_POP : S_NB_READ;
			end
			S_TR_READ: begin
				if (stat.tr_at_start) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_FOUND;
					state_d        = S_IDLE;
				end else begin
					cmd.tr_read = 1'b1;
					state_d     = S_TR_WAIT;
				end
			end
			S_TR_WAIT: begin
				cmd.tr_step = 1'b1;
				state_d     = S_TR_READ;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- hw/rtl/gmb_dp.sv -----
// Datapath of the grid maze BFS solver: grid, visit and queue memories, pointers.
`timescale 1ns / 1ps
module gmb_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [gmb_pkg::DIM_W-1:0]     cfg_data,
	input  logic [gmb_pkg::ROW_W-1:0]     row,
	input  logic [gmb_pkg::COL_W-1:0]     col,
	input  logic [1:0]                    cell_code,
	input  gmb_pkg::cmd_t                 cmd,
	output gmb_pkg::stat_t                stat,
	output logic [1:0]                    status,
	output logic [2:0]                    cell_value
);
	import gmb_pkg::*;

	localparam int CELLS = 1 << CELL_W;

	logic [2:0]        grid_mem  [CELLS];
	logic [2:0]        visit_mem [CELLS];
	logic [CELL_W-1:0] queue_mem [CELLS];

	logic [DIM_W-1:0]  rows_cfg_q, cols_cfg_q;
	logic [DIM_W-1:0]  rows_c, cols_c;

	logic [2:0]        grid_rd_q, visit_rd_q;
	logic [CELL_W-1:0] queue_rd_q;

	logic [CELL_W-1:0] sw_addr_q, sw_addr_s1;
	logic              sw_v_s1;
	logic [1:0]        n_start_q, n_finish_q;
	logic [CELL_W-1:0] start_q, finish_q;
	logic [PTR_W-1:0]  head_q, tail_q;
	logic [CELL_W-1:0] cur_q, nb_q, tr_q;
	dir_t              dir_q;

	logic [ROW_W-1:0]  cur_r;
	logic [COL_W-1:0]  cur_c;
	logic [CELL_W-1:0] nb_addr;
	logic              nb_ok;
	logic              enq;

	logic              g_we;
	logic [CELL_W-1:0] g_wa, g_ra;
	logic [2:0]        g_wd;
	logic              v_we;
	logic [CELL_W-1:0] v_wa, v_ra;
	logic [2:0]        v_wd;
	logic              q_we;
	logic [CELL_W-1:0] q_wa, q_wd;

	status_t           res_status_q;
	logic [2:0]        res_value_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_cfg_q <= DIM_MAX_ROWS;
			cols_cfg_q <= DIM_MAX_COLS;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ROWS) rows_cfg_q <= cfg_data;
			else cols_cfg_q <= cfg_data;
		end
	end

	assign rows_c = clamp_dim(rows_cfg_q, DIM_MAX_ROWS);
	assign cols_c = clamp_dim(cols_cfg_q, DIM_MAX_COLS);

	// Neighbor address and edge check for the current direction
	assign cur_r = cur_q[CELL_W-1:COL_W];
	assign cur_c = cur_q[COL_W-1:0];

	always_comb begin
		case (dir_q)
			DIR_N: begin
				nb_ok   = (cur_r != '0);
				nb_addr = cur_q - CELL_W'(MAX_COLS);
			end
			DIR_W: begin
				nb_ok   = (cur_c != '0);
				nb_addr = cur_q - CELL_W'(1);
			end
			DIR_S: begin
				nb_ok   = ({1'b0, cur_r} + DIM_W'(1)) < rows_c;
				nb_addr = cur_q + CELL_W'(MAX_COLS);
			end
			default: begin
				nb_ok   = ({1'b0, cur_c} + DIM_W'(1)) < cols_c;
				nb_addr = cur_q + CELL_W'(1);
			end
		endcase
	end

	assign enq = cmd.nb_check && (grid_rd_q != CODE_WALL) && !visit_rd_q[2]
		&& !tail_q[PTR_W-1];

	// Memory port selection
	always_comb begin
		g_we = 1'b0;
		g_wa = {row, col};
		g_wd = {1'b0, cell_code};
		if (cmd.item_wr) begin
			g_we = 1'b1;
		end else if (cmd.tr_step && (tr_q != finish_q)) begin
			g_we = 1'b1;
			g_wa = tr_q;
			g_wd = CODE_PATH;
		end
		if (cmd.item_rd) g_ra = {row, col};
		else if (cmd.sweep_run) g_ra = sw_addr_q;
		else g_ra = nb_addr;

		v_we = 1'b0;
		v_wa = sw_addr_q;
		v_wd = 3'd0;
		if (cmd.sweep_run) begin
			v_we = 1'b1;
		end else if (cmd.seed) begin
			v_we = 1'b1;
			v_wa = start_q;
			v_wd = 3'b100;
		end else if (enq) begin
			v_we = 1'b1;
			v_wa = nb_q;
			v_wd = {1'b1, dir_q};
		end
		v_ra = cmd.tr_read ? tr_q : nb_addr;

		q_we = cmd.seed || enq;
		q_wa = cmd.seed ? '0 : tail_q[CELL_W-1:0];
		q_wd = cmd.seed ? start_q : nb_q;
	end

	// Grid memory
	always_ff @(posedge clk) begin
		if (g_we) grid_mem[g_wa] <= g_wd;
		grid_rd_q <= grid_mem[g_ra];
	end

	// Visit and direction memory
	always_ff @(posedge clk) begin
		if (v_we) visit_mem[v_wa] <= v_wd;
		visit_rd_q <= visit_mem[v_ra];
	end

	// Frontier queue memory
	always_ff @(posedge clk) begin
		if (q_we) queue_mem[q_wa] <= q_wd;
		queue_rd_q <= queue_mem[head_q[CELL_W-1:0]];
	end

	// Control registers: sweep, counts, queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_addr_q  <= '0;
			sw_v_s1    <= 1'b0;
			n_start_q  <= '0;
			n_finish_q <= '0;
			start_q    <= '0;
			finish_q   <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			dir_q      <= DIR_N;
		end else begin
			sw_v_s1 <= cmd.sweep_run;
			if (cmd.sweep_init) begin
				sw_addr_q  <= '0;
				n_start_q  <= '0;
				n_finish_q <= '0;
			end else if (cmd.sweep_run) begin
				sw_addr_q <= sw_addr_q + CELL_W'(1);
			end
			// Count start and finish codes inside the active region
			if (sw_v_s1 && ({1'b0, sw_addr_s1[CELL_W-1:COL_W]} < rows_c)
				&& ({1'b0, sw_addr_s1[COL_W-1:0]} < cols_c)) begin
				if (grid_rd_q == CODE_START) begin
					start_q <= sw_addr_s1;
					if (n_start_q != 2'd2) n_start_q <= n_start_q + 2'd1;
				end else if (grid_rd_q == CODE_FINISH) begin
					finish_q <= sw_addr_s1;
					if (n_finish_q != 2'd2) n_finish_q <= n_finish_q + 2'd1;
				end
			end
			if (cmd.seed) begin
				head_q <= '0;
				tail_q <= PTR_W'(1);
			end else begin
				if (cmd.pop) head_q <= head_q + PTR_W'(1);
				if (enq) tail_q <= tail_q + PTR_W'(1);
			end
			if (cmd.load_cur) dir_q <= DIR_N;
			else if (cmd.nb_check || cmd.dir_next) dir_q <= dir_t'(dir_q + 2'd1);
		end
	end

	// Payload registers: sweep address stage, cells under work, result
	always_ff @(posedge clk) begin
		sw_addr_s1 <= sw_addr_q;
		if (cmd.load_cur) cur_q <= queue_rd_q;
		if (cmd.nb_read) nb_q <= nb_addr;
		if (cmd.tr_init) begin
			tr_q <= finish_q;
		end else if (cmd.tr_step) begin
			case (dir_t'(visit_rd_q[1:0]))
				DIR_N:   tr_q <= tr_q + CELL_W'(MAX_COLS);
				DIR_W:   tr_q <= tr_q + CELL_W'(1);
				DIR_S:   tr_q <= tr_q - CELL_W'(MAX_COLS);
				default: tr_q <= tr_q - CELL_W'(1);
			endcase
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_value_q  <= cmd.res_use_rd ? grid_rd_q : CODE_OPEN;
		end
	end

	assign stat.sweep_last    = (sw_addr_q == '1);
	assign stat.maze_ok       = (n_start_q == 2'd1) && (n_finish_q == 2'd1);
	assign stat.queue_empty   = (head_q == tail_q);
	assign stat.cur_is_finish = (cur_q == finish_q);
	assign stat.nb_ok         = nb_ok;
	assign stat.dir_last      = (dir_q == DIR_E);
	assign stat.tr_at_start   = (tr_q == start_q);

	assign status     = res_status_q;
	assign cell_value = res_value_q;

endmodule

// ----- hw/rtl/grid_maze_bfs_shortest_path.sv -----
// Top level of the grid maze BFS solver: stream ports, controller and datapath.
`timescale 1ns / 1ps
// A 64 x 64 grid is loaded and read back one cell per beat and solved by a
// breadth-first search over rows 0..row_count-1 and columns 0..col_count-1.
// Every input beat yields exactly one result beat, and a new beat is taken
// only once the previous result has been taken. A write or an unused opcode
// loads its result when accepted, a read from the registered grid memory
// read. A solve first sweeps all 4096 cells, clearing the visit memory and
// counting start and finish codes; the search then dequeues cells and tests
// their neighbors, and the trace-back marks the path cells, all through the
// single read port of each memory.
module grid_maze_bfs_shortest_path (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // opcode[1:0], row[7:2], col[13:8], cell_code[15:14]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // status[1:0], cell_value[4:2], zero[7:5]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);
	import gmb_pkg::*;

	cmd_t       cmd;
	stat_t      stat;
	logic [1:0] status;
	logic [2:0] cell_value;

	gmb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.opcode   (op_t'(s_tdata[1:0])),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gmb_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.row        (s_tdata[7:2]),
		.col        (s_tdata[13:8]),
		.cell_code  (s_tdata[15:14]),
		.cmd        (cmd),
		.stat       (stat),
		.status     (status),
		.cell_value (cell_value)
	);

	assign m_tdata = {3'b000, cell_value, status};

	// Input is taken only while no result waits
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready while a result is pending");

	// An accepted beat closes the input until its result is out
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after an accepted beat");

	// A result appears only after an accepted beat or at the end of work on one
	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready || s_tvalid))
		else $error("result raised while the block was idle");

endmodule

// ----- tb/grid_maze_bfs_shortest_path_tb.sv -----
// Self-checking testbench of the grid maze BFS solver.
`timescale 1ns / 1ps
module grid_maze_bfs_shortest_path_tb;
	import gmb_pkg::*;

	localparam int CELLS      = MAX_ROWS * MAX_COLS;
	localparam int IDLE_LIMIT = 200000;
	localparam int RAND_ITEMS = 700;

	typedef struct packed {
		status_t    status;
		logic [2:0] cell_value;
	} answer_t;

	// One row of the directed table: a register pair or an item
	typedef struct {
		bit         is_dims;
		logic [6:0] rows_raw;
		logic [6:0] cols_raw;
		op_t        op;
		logic [5:0] row;
		logic [5:0] col;
		logic [1:0] code;
		bit         typed;
		status_t    status;
		logic [2:0] cell_value;
	} drow_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        cfg_we;
	logic        cfg_index;
	logic [6:0]  cfg_data;

	// Mirror of the block: grid, dimensions, search scratch
	logic [2:0]  maze[CELLS];
	bit          seen[CELLS];
	logic [1:0]  came_from[CELLS];
	int          frontier[CELLS];
	logic [6:0]  rows_reg;
	logic [6:0]  cols_reg;

	answer_t     pending[$];
	answer_t     typed_ans[$];
	bit          typed_flag[$];
	int          errors;
	int          idle_cycles;
	int          n_found, n_nopath, n_invalid, n_reads, n_items;
	bit          stall_req;
	bit          no_idle;

	grid_maze_bfs_shortest_path dut (.*);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int eff_dim(logic [6:0] v);
		if (v == 0) return 1;
		if (v > 64) return 64;
		return int'(v);
	endfunction

	// Breadth-first search over the active region, marks the path
	function automatic status_t solve_maze();
		int rows, cols, ns, nf, start_idx, finish_idx;
		int head, tail, cur, r, c, nidx, idx;
		bit found, ok;
		rows = eff_dim(rows_reg);
		cols = eff_dim(cols_reg);
		ns = 0;
		nf = 0;
		start_idx = 0;
		finish_idx = 0;
		found = 0;
		for (int i = 0; i < rows; i++)
			for (int j = 0; j < cols; j++) begin
				idx = i * MAX_COLS + j;
				if (maze[idx] == CODE_START) begin
					ns++;
					start_idx = idx;
				end else if (maze[idx] == CODE_FINISH) begin
					nf++;
					finish_idx = idx;
				end
			end
		if (ns != 1 || nf != 1) return ST_INVALID;
		for (int i = 0; i < CELLS; i++) seen[i] = 0;
		seen[start_idx] = 1;
		frontier[0] = start_idx;
		head = 0;
		tail = 1;
		while (head < tail) begin
			cur = frontier[head];
			head++;
			if (cur == finish_idx) begin
				found = 1;
				break;
			end
			r = cur / MAX_COLS;
			c = cur % MAX_COLS;
			// neighbors in order north, west, south, east
			for (int d = 0; d < 4; d++) begin
				case (dir_t'(d))
					DIR_N: begin ok = r > 0; nidx = cur - MAX_COLS; end
					DIR_W: begin ok = c > 0; nidx = cur - 1; end
					DIR_S: begin ok = r + 1 < rows; nidx = cur + MAX_COLS; end
					default: begin ok = c + 1 < cols; nidx = cur + 1; end
				endcase
				if (ok && maze[nidx] != CODE_WALL && !seen[nidx]) begin
					seen[nidx] = 1;
					came_from[nidx] = d[1:0];
					frontier[tail] = nidx;
					tail++;
				end
			end
		end
		if (!found) return ST_NOPATH;
		// trace back from the finish, marking cells between the ends
		idx = finish_idx;
		while (idx != start_idx) begin
			if (idx != finish_idx) maze[idx] = CODE_PATH;
			case (dir_t'(came_from[idx]))
				DIR_N: idx += MAX_COLS;
				DIR_W: idx += 1;
				DIR_S: idx -= MAX_COLS;
				default: idx -= 1;
			endcase
		end
		return ST_FOUND;
	endfunction

	function automatic answer_t predict(op_t op, logic [5:0] row, logic [5:0] col,
		logic [1:0] code);
		answer_t a;
		a = '{ST_ACK, 3'd0};
		case (op)
			OP_WRITE: maze[row * MAX_COLS + col] = {1'b0, code};
			OP_SOLVE: begin
				a.status = solve_maze();
				case (a.status)
					ST_FOUND: n_found++;
					ST_NOPATH: n_nopath++;
					default: n_invalid++;
				endcase
			end
			OP_READ: begin
				a.cell_value = maze[row * MAX_COLS + col];
				n_reads++;
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic int pick_gap();
		int p;
		if (no_idle) return 0;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one beat, record its expectation once taken
	task automatic send(op_t op, logic [5:0] row, logic [5:0] col, logic [1:0] code,
		bit typed = 0, answer_t want = '0);
		int gap;
		answer_t a;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {code, col, row, op};
		do @(posedge clk); while (!s_tready);
		a = predict(op, row, col, code);
		if (typed && a != want) begin
			$error("predictor disagrees with table: expected %p got %p", want, a);
			errors++;
		end
		pending.push_back(typed ? want : a);
		n_items++;
	endtask

	// Wait for every answer, then write both dimension registers
	task automatic set_dims(logic [6:0] rows_v, logic [6:0] cols_v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ROWS;
		cfg_data  <= rows_v;
		@(posedge clk);
		cfg_index <= CFG_COLS;
		cfg_data  <= cols_v;
		@(posedge clk);
		cfg_we <= 1'b0;
		rows_reg = rows_v;
		cols_reg = cols_v;
	endtask

	// Result checker
	always @(posedge clk) begin
		answer_t want;
		if (m_tvalid && m_tready) begin
			if (pending.size() == 0) begin
				$error("result beat with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				want = pending.pop_front();
				if (m_tdata[1:0] !== want.status) begin
					$error("status: expected %0d actual %0d", want.status, m_tdata[1:0]);
					errors++;
				end
				if (m_tdata[4:2] !== want.cell_value) begin
					$error("cell_value: expected %0d actual %0d", want.cell_value,
						m_tdata[4:2]);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: random ready pattern with one long hold-off on request
	initial begin
		int p;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (stall_req) begin
				m_tready <= 1'b0;
				repeat (500) @(posedge clk);
				stall_req = 0;
			end
			p = $urandom_range(0, 99);
			if (no_idle || p < 55) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else if (p < 93) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(20, 60)) @(posedge clk);
			end
		end
	end

	// Main sequence
	initial begin
		drow_t tbl[$];
		int rows, cols, nsolve, r0, c0, r1, c1, p, op_v;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_ROWS;
		cfg_data  = '0;
		arst_n    = 1'b0;
		errors    = 0;
		stall_req = 0;
		no_idle   = 0;
		rows_reg  = 7'd64;
		cols_reg  = 7'd64;
		for (int i = 0; i < CELLS; i++) maze[i] = CODE_OPEN;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill row 0 and column 0, the only cells the directed rows search or read unwritten
		no_idle = 1;
		for (int i = 0; i < MAX_COLS; i++)
			send(OP_WRITE, 6'd0, 6'(i), 2'(CODE_OPEN));
		for (int i = 1; i < MAX_ROWS; i++)
			send(OP_WRITE, 6'(i), 6'd0, 2'(CODE_OPEN));
		no_idle = 0;

		// Directed table
		tbl = '{
			'{0, 0, 0, OP_READ,   0,  0,  0, 1, ST_ACK, CODE_OPEN},
			'{0, 0, 0, OP_WRITE,  0,  0,  3, 1, ST_ACK, 0},
			'{0, 0, 0, OP_READ,   0,  0,  0, 1, ST_ACK, CODE_FINISH},
			'{0, 0, 0, OP_WRITE, 63, 63,  2, 1, ST_ACK, 0},
			'{0, 0, 0, OP_READ,  63, 63,  0, 1, ST_ACK, CODE_START},
			'{0, 0, 0, OP_NOP,   63, 63,  3, 1, ST_ACK, 0},
			'{1, 1, 1, OP_NOP,    0,  0,  0, 0, ST_ACK, 0},
			'{0, 0, 0, OP_SOLVE,  0,  0,  0, 1, ST_INVALID, 0},
			'{1, 0, 127, OP_NOP,  0,  0,  0, 0, ST_ACK, 0},
			'{0, 0, 0, OP_SOLVE,  0,  0,  0, 1, ST_INVALID, 0},
			'{0, 0, 0, OP_WRITE,  0, 63,  2, 1, ST_ACK, 0},
			'{0, 0, 0, OP_SOLVE,  0,  0,  0, 1, ST_FOUND, 0},
			'{0, 0, 0, OP_READ,   0, 10,  0, 1, ST_ACK, CODE_PATH},
			'{1, 127, 0, OP_NOP,  0,  0,  0, 0, ST_ACK, 0},
			'{0, 0, 0, OP_WRITE, 63,  0,  2, 1, ST_ACK, 0},
			'{0, 0, 0, OP_WRITE, 32,  0,  1, 1, ST_ACK, 0},
			'{0, 0, 0, OP_SOLVE,  0,  0,  0, 1, ST_NOPATH, 0},
			'{0, 0, 0, OP_WRITE,  1,  0,  2, 1, ST_ACK, 0},
			'{0, 0, 0, OP_SOLVE,  0,  0,  0, 1, ST_INVALID, 0},
			'{1, 64, 64, OP_NOP,  0,  0,  0, 0, ST_ACK, 0}
		};
		foreach (tbl[i]) begin
			if (tbl[i].is_dims) set_dims(tbl[i].rows_raw, tbl[i].cols_raw);
			else send(tbl[i].op, tbl[i].row, tbl[i].col, tbl[i].code, tbl[i].typed,
				'{tbl[i].status, tbl[i].cell_value});
		end

		// Random mazes: load region, place ends, add noise, solve, read back
		stall_req = 1;
		while (n_items < RAND_ITEMS) begin
			p = $urandom_range(0, 99);
			if (p < 80) set_dims(7'($urandom_range(1, 12)), 7'($urandom_range(1, 12)));
			else if (p < 85) set_dims(7'd0, 7'($urandom_range(1, 12)));
			else if (p < 90) set_dims(7'($urandom_range(0, 1)), 7'd127);
			else if (p < 95) set_dims(7'd64, 7'($urandom_range(0, 1)));
			else set_dims(7'($urandom_range(65, 127)), 7'($urandom_range(0, 1)));
			rows = eff_dim(rows_reg);
			cols = eff_dim(cols_reg);
			no_idle = ($urandom_range(0, 5) == 0);
			for (int i = 0; i < rows; i++)
				for (int j = 0; j < cols; j++)
					send(OP_WRITE, 6'(i), 6'(j),
						($urandom_range(0, 3) == 0) ? 2'(CODE_WALL) : 2'(CODE_OPEN));
			r0 = $urandom_range(0, rows - 1);
			c0 = $urandom_range(0, cols - 1);
			r1 = $urandom_range(0, rows - 1);
			c1 = $urandom_range(0, cols - 1);
			p = $urandom_range(0, 99);
			if (p >= 5) send(OP_WRITE, 6'(r0), 6'(c0), 2'(CODE_START));
			if (p < 95 || p < 5) send(OP_WRITE, 6'(r1), 6'(c1), 2'(CODE_FINISH));
			if (p >= 88 && p < 95)
				send(OP_WRITE, 6'($urandom_range(0, rows - 1)),
					6'($urandom_range(0, cols - 1)), 2'(CODE_START));
			// noise on any address: writes and the unused opcode
			repeat ($urandom_range(0, 4)) begin
				op_v = ($urandom_range(0, 1) == 0) ? int'(OP_WRITE) : int'(OP_NOP);
				send(op_t'(op_v), 6'($urandom), 6'($urandom), 2'($urandom));
			end
			nsolve = ($urandom_range(0, 4) == 0) ? 2 : 1;
			repeat (nsolve) send(OP_SOLVE, 6'($urandom), 6'($urandom), 2'($urandom));
			repeat ($urandom_range(2, 6))
				send(OP_READ, 6'($urandom_range(0, rows - 1)),
					6'($urandom_range(0, cols - 1)), 2'($urandom));
		end
		no_idle = 0;
		s_tvalid <= 1'b0;

		// Drain and settle
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Covered %0d solves found, %0d without path, %0d invalid mazes;",
			n_found, n_nopath, n_invalid);
		$display("%0d cell reads over all dimension extremes, with stalls.", n_reads);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
